// ===== sv/pwg_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the PMBus write gate.
// No dependencies; imported by every module of the block.
`default_nettype none

package pwg_pkg;

    // Verdict codes given with each finished transaction
    typedef enum logic [2:0] {
        V_FORWARD  = 3'd0,
        V_SKIP     = 3'd1,
        V_SECURITY = 3'd2,
        V_BADLEN   = 3'd3,
        V_NOPEC    = 3'd4,
        V_MISMATCH = 3'd5
    } verdict_t;

    // Transaction kinds; anything at or above block write is a block write
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;

    // Configuration register indexes
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_INC_LEN  = 1'b1;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] CMD_PASSKEY = 8'h0E;
    localparam logic [7:0] BYTE_LEN    = 8'd1;
    localparam logic [7:0] WORD_LEN    = 8'd2;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified request as it travels from front to back
    typedef struct packed {
        logic       first;
        logic [7:0] hdr_pec;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       last;
        verdict_t   pre_verdict;
        logic       pec_check;
        logic [7:0] expected_pec;
    } q_entry_t;

    // SMBus PEC: CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic is_read_only(input logic [7:0] c);
        logic ro;
        case (c) inside
            8'h24, 8'h28, 8'h47, 8'h98, 8'h99,
            8'hC8, 8'hDD, 8'hDE, 8'hDF, 8'hE0: ro = 1'b1;
            default:                           ro = 1'b0;
        endcase
        return ro;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pwg_front.sv =====
// Front end: configuration registers, request accept and classification.
// Depends on pwg_pkg; feeds pwg_queue.
`default_nettype none

module pwg_front
    import pwg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] cmd_code,
    input  wire logic [7:0] data_count,
    input  wire logic [7:0] data_byte,
    input  wire logic       data_valid,
    input  wire logic       first,
    input  wire logic       last,
    input  wire logic       has_pec,
    input  wire logic [7:0] expected_pec,
    input  wire logic       q_full,
    output logic            push,
    output q_entry_t        push_entry
);

    logic [6:0] dev_addr_reg;
    logic       inc_len_reg;
    logic [7:0] hdr;
    logic       block;
    verdict_t   pre;
    logic       chk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 7'd0;
            inc_len_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEV_ADDR: dev_addr_reg <= cfg_data;
                CFG_INC_LEN:  inc_len_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Header PEC: address with write bit, command, optional length byte
    always_comb
    begin
        block = kind[1];
        hdr   = crc8_byte(8'd0, {dev_addr_reg, 1'b0});
        hdr   = crc8_byte(hdr, cmd_code);
        if (block && inc_len_reg)
            hdr = crc8_byte(hdr, data_count);
    end

    // Decide everything but the PEC compare, in the order each kind checks
    always_comb
    begin
        pre = V_FORWARD;
        chk = 1'b0;
        if (kind == KIND_BYTE && data_count != BYTE_LEN)
            pre = V_BADLEN;
        else if (kind == KIND_WORD && data_count == 8'd0)
            pre = V_BADLEN;
        else if (is_read_only(cmd_code))
            pre = V_SKIP;
        else if (cmd_code == CMD_PASSKEY)
            pre = V_SECURITY;
        else if (!has_pec || (kind == KIND_WORD && data_count != WORD_LEN))
            pre = V_NOPEC;
        else
            chk = 1'b1;
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_entry.first        = first;
        push_entry.hdr_pec      = hdr;
        push_entry.data_valid   = data_valid;
        push_entry.data_byte    = data_byte;
        push_entry.last         = last;
        push_entry.pre_verdict  = pre;
        push_entry.pec_check    = chk;
        push_entry.expected_pec = expected_pec;
    end

endmodule

`default_nettype wire

// ===== sv/pwg_queue.sv =====
// Short register queue of classified requests between front and back.
// Depends on pwg_pkg.
`default_nettype none

module pwg_queue
    import pwg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  q_entry_t  push_entry,
    output logic      full,
    input  wire logic pop,
    output q_entry_t  head,
    output logic      empty
);

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ===== sv/pwg_back.sv =====
// Back end: running PEC, final compare and the output register.
// Depends on pwg_pkg; drains pwg_queue.
`default_nettype none

module pwg_back
    import pwg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  q_entry_t   head,
    input  wire logic  empty,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [2:0] verdict,
    output logic [7:0] computed_pec
);

    logic [7:0] pec_reg, pec_next;
    logic       out_valid_reg, out_valid_next;
    verdict_t   verdict_reg;
    logic [7:0] pec_out_reg;
    logic [7:0] pec_cur;
    verdict_t   fin;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    // A non-last request needs no output slot
    assign pop = !empty && (!head.last || slot_free);

    always_comb
    begin
        pec_cur = head.first ? head.hdr_pec : pec_reg;
        if (head.data_valid)
            pec_cur = crc8_byte(pec_cur, head.data_byte);
        fin = head.pre_verdict;
        if (head.pec_check)
            fin = (pec_cur != head.expected_pec) ? V_MISMATCH : V_FORWARD;
    end

    always_comb
    begin
        pec_next       = pec_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            // Restart from zero once a transaction closes
            pec_next = head.last ? 8'd0 : pec_cur;
            if (head.last)
                out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pec_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pec_reg       <= pec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            verdict_reg <= fin;
            pec_out_reg <= pec_cur;
        end
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = verdict_reg;
    assign computed_pec = pec_out_reg;

endmodule

`default_nettype wire

// ===== sv/pmbus_write_gate_pec_check.sv =====
// PMBus write gate with SMBus PEC check (CRC-8, polynomial 0x07).
//
// Input channel (in_valid / in_stall): one request per bus data byte of a
// write byte, write word or block write. first opens a transaction, last
// closes it. Output channel (out_valid / out_stall): one verdict and the
// computed PEC per transaction, produced on its last request only.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 device address, 1 include block length); write only while idle.
// Throughput: one request per cycle while the queue is not full. The front
// classifies a request and computes the header PEC in its accept cycle; a
// two-entry queue decouples it from the back, which folds one data byte per
// cycle into the running PEC unless a last request waits for the output
// slot. A last request is queued, then the back registers its result.
// When out_stall holds a result, the back keeps draining requests that are
// not last; in_stall rises only once the queue is full. Reset: running PEC
// clears to zero, queue and output empty, device address 0, include length 1.
`default_nettype none

module pmbus_write_gate_pec_check
    import pwg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] cmd_code,
    input  wire logic [7:0] data_count,
    input  wire logic [7:0] data_byte,
    input  wire logic       data_valid,
    input  wire logic       first,
    input  wire logic       last,
    input  wire logic       has_pec,
    input  wire logic [7:0] expected_pec,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      verdict,
    output logic [7:0]      computed_pec
);

    logic     q_full;
    logic     q_empty;
    logic     push;
    logic     pop;
    q_entry_t push_entry;
    q_entry_t head;

    pwg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .cmd_code     (cmd_code),
        .data_count   (data_count),
        .data_byte    (data_byte),
        .data_valid   (data_valid),
        .first        (first),
        .last         (last),
        .has_pec      (has_pec),
        .expected_pec (expected_pec),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    pwg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    pwg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .verdict      (verdict),
        .computed_pec (computed_pec)
    );

endmodule

`default_nettype wire
